/* sv/gdn_pkg.sv */
`timescale 1ns / 1ps

package gdn_pkg;

    // Field widths of the request and the result.
    localparam int YEAR_W  = 14;
    localparam int MON_W   = 4;
    localparam int DAY_FW  = 5;
    localparam int OFS_W   = 21;
    localparam int DIFF_W  = 22;

    // Internal widths. DAY_W holds a signed day number for any supported
    // maximum year, YREG_W a computed year up to that maximum.
    localparam int DAY_W   = 27;
    localparam int YREG_W  = 16;
    localparam int K_W     = 3;

    localparam int DEF_MAX_YEAR = 9999;

    // Largest difference the result field can carry.
    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

    // A 14-bit year count holds at most 40 blocks of 400 years.
    localparam logic [K_W-1:0] FWD_K400 = 3'd5;

    typedef logic signed [DAY_W-1:0] dnum_t;

    typedef enum logic [1:0] {
        LVL_400 = 2'd0,
        LVL_100 = 2'd1,
        LVL_4   = 2'd2,
        LVL_1   = 2'd3
    } lvl_t;

    // Result of one pass through the shared step unit.
    typedef struct packed {
        dnum_t diff;
        logic  take;
        dnum_t sum;
    } step_res_t;

    function automatic dnum_t year_block(input lvl_t lvl);
        dnum_t v;
        unique case (lvl)
            LVL_400: v = dnum_t'(400);
            LVL_100: v = dnum_t'(100);
            LVL_4:   v = dnum_t'(4);
            default: v = dnum_t'(1);
        endcase
        return v;
    endfunction

    function automatic dnum_t day_block(input lvl_t lvl);
        dnum_t v;
        unique case (lvl)
            LVL_400: v = dnum_t'(146097);
            LVL_100: v = dnum_t'(36524);
            LVL_4:   v = dnum_t'(1461);
            default: v = dnum_t'(365);
        endcase
        return v;
    endfunction

    // Highest power-of-two multiple tried at each block level.
    function automatic logic [K_W-1:0] blk_kmax(input lvl_t lvl);
        logic [K_W-1:0] v;
        unique case (lvl)
            LVL_400: v = FWD_K400;
            LVL_100: v = 3'd1;
            LVL_4:   v = 3'd4;
            default: v = 3'd1;
        endcase
        return v;
    endfunction

    function automatic lvl_t lvl_succ(input lvl_t lvl);
        lvl_t v;
        unique case (lvl)
            LVL_400: v = LVL_100;
            LVL_100: v = LVL_4;
            default: v = LVL_1;
        endcase
        return v;
    endfunction

    // Month numbers past twelve count thirty days each.
    function automatic logic [DAY_FW-1:0] month_len(input logic [MON_W-1:0] mon,
                                                    input logic leap);
        logic [DAY_FW-1:0] v;
        case (mon) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd2:                                       v = leap ? 5'd29 : 5'd28;
            default:                                    v = 5'd30;
        endcase
        return v;
    endfunction

endpackage

/* sv/gdn_step.sv */
`timescale 1ns / 1ps

// Shared step unit: one trial subtract with its sign as the compare, and
// one accumulate.
module gdn_step
    import gdn_pkg::*;
(
    input  dnum_t     a,
    input  dnum_t     b,
    input  dnum_t     c,
    input  dnum_t     e,
    output step_res_t res
);

    always_comb
    begin
        res.diff = a - b;
        res.take = ~res.diff[DAY_W-1];
        res.sum  = c + e;
    end

endmodule

/* sv/gregorian_day_number_arith.sv */
`timescale 1ns / 1ps

// Proleptic Gregorian date arithmetic, day 1 being 0001-01-01. A request
// with action 0 adds day_offset to the first date and returns the shifted
// date, saturated to 0001-01-01 or MAX_YEAR-12-31 with range_error set when
// it falls outside; a request with action 1 returns the days from the first
// to the second date, at least 1. A request is taken when start is high and
// busy is low; the result is on the result ports for exactly one cycle while
// done is high, and the receiver cannot stall it, so it must capture the
// result in that cycle. All work runs through one shared subtract-and-
// accumulate unit, one trial of a 400, 100, 4 or 1 year block or one month
// per cycle. A date is converted to a day number by block trials on its
// whole years, then one month step for each month before its own, then
// the day; an add then adds the offset, clamps it at the low and the high
// end, turns the day number back into years by block trials, fixes the
// year and searches the month; a between request converts both dates and
// subtracts them. Month numbers past twelve count thirty days each in the
// month steps. busy falls in the cycle done is high, and a new request may
// be given in that cycle.
module gregorian_day_number_arith
    import gdn_pkg::*;
#(
    parameter int MAX_YEAR = DEF_MAX_YEAR
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     action,
    input  logic [YEAR_W-1:0]        first_year,
    input  logic [MON_W-1:0]         first_month,
    input  logic [DAY_FW-1:0]        first_day,
    input  logic [YEAR_W-1:0]        second_year,
    input  logic [MON_W-1:0]         second_month,
    input  logic [DAY_FW-1:0]        second_day,
    input  logic signed [OFS_W-1:0]  day_offset,
    output logic                     done,
    output logic [YEAR_W-1:0]        result_year,
    output logic [MON_W-1:0]         result_month,
    output logic [DAY_FW-1:0]        result_day,
    output logic [DIFF_W-1:0]        day_difference,
    output logic                     range_error
);

    // Day number of MAX_YEAR-12-31 and the number of 400-year doublings
    // the date conversion has to try. A leap MAX_YEAR ends one day later.
    localparam int LY        = MAX_YEAR - 1;
    localparam int LAST_LEAP = (((MAX_YEAR % 4 == 0) && (MAX_YEAR % 100 != 0)) ||
                                (MAX_YEAR % 400 == 0)) ? 1 : 0;
    localparam int LAST_DAY  = 365 * LY + LY / 4 - LY / 100 + LY / 400 + 365 + LAST_LEAP;
    localparam dnum_t LAST_M1 = dnum_t'(LAST_DAY - 1);
    localparam logic [K_W-1:0] R_K400 = K_W'($clog2(MAX_YEAR / 400 + 1) - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FYEAR = 10'b0000000010,
        S_FMON  = 10'b0000000100,
        S_OFS   = 10'b0000001000,
        S_LOW   = 10'b0000010000,
        S_HIGH  = 10'b0000100000,
        S_RYEAR = 10'b0001000000,
        S_RYFIX = 10'b0010000000,
        S_RMON  = 10'b0100000000,
        S_DIFF  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Working registers of the sequencer. rem holds whole years while a
    // date is converted to a day number and days while a day number is
    // converted back; acc collects the other unit.
    dnum_t             rem_reg, rem_next;
    dnum_t             acc_reg, acc_next;
    dnum_t             n1_reg, n1_next;
    lvl_t              lvl_reg, lvl_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [1:0]        qa_reg, qa_next;
    logic [4:0]        qb_reg, qb_next;
    logic [1:0]        qc_reg, qc_next;
    logic              yzero_reg, yzero_next;
    logic [MON_W-1:0]  mon_reg, mon_next;
    logic [MON_W-1:0]  cur_m_reg, cur_m_next;
    logic [DAY_FW-1:0] cur_d_reg, cur_d_next;
    logic              pass_reg, pass_next;
    logic              err_reg, err_next;
    logic [YREG_W-1:0] year_reg, year_next;

    // The request fields used after the first cycle.
    logic                    action_reg, action_next;
    logic [YEAR_W-1:0]       sy_reg, sy_next;
    logic [MON_W-1:0]        sm_reg, sm_next;
    logic [DAY_FW-1:0]       sd_reg, sd_next;
    logic signed [OFS_W-1:0] off_reg, off_next;

    logic                done_reg, done_next;
    logic [YEAR_W-1:0]   ryear_reg, ryear_next;
    logic [MON_W-1:0]    rmon_reg, rmon_next;
    logic [DAY_FW-1:0]   rday_reg, rday_next;
    logic [DIFF_W-1:0]   rdiff_reg, rdiff_next;
    logic                rerr_reg, rerr_next;

    dnum_t     op_a, op_b, op_c, op_e;
    step_res_t step;
    logic      leap;
    logic      mon_more;
    logic      accept;

    gdn_step u_step (
        .a   (op_a),
        .b   (op_b),
        .c   (op_c),
        .e   (op_e),
        .res (step)
    );

    // Whole years before a date; year zero counts none, like year one.
    function automatic dnum_t year_base(input logic [YEAR_W-1:0] y);
        return (y > 14'd1) ? dnum_t'(y - 14'd1) : '0;
    endfunction

    // The block digits of (year - 1) mod 400 tell whether the year is a
    // leap year: the last year of a four-year group is leap, unless it
    // closes a century that does not close the 400-year cycle. Year zero
    // is taken as a multiple of 400.
    assign leap = yzero_reg ||
                  ((qc_reg == 2'd3) && ((qb_reg != 5'd24) || (qa_reg == 2'd3)));

    assign mon_more = (mon_reg < cur_m_reg);
    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);

    // Operand selection for the shared unit.
    always_comb
    begin
        op_a = rem_reg;
        op_b = '0;
        op_c = acc_reg;
        op_e = '0;
        unique case (state_reg)
            S_FYEAR:
            begin
                op_b = year_block(lvl_reg) << k_reg;
                op_e = day_block(lvl_reg) << k_reg;
            end
            S_RYEAR:
            begin
                op_b = day_block(lvl_reg) << k_reg;
                op_e = year_block(lvl_reg) << k_reg;
            end
            S_FMON:
            begin
                op_e = mon_more ? dnum_t'(month_len(mon_reg, leap)) : dnum_t'(cur_d_reg);
            end
            S_OFS:
            begin
                op_e = {{(DAY_W - OFS_W){off_reg[OFS_W-1]}}, off_reg};
            end
            S_LOW:
            begin
                op_a = acc_reg;
                op_b = dnum_t'(1);
            end
            S_HIGH:
            begin
                op_a = LAST_M1;
            end
            S_RYFIX:
            begin
                op_e = dnum_t'(1);
            end
            S_RMON:
            begin
                op_b = dnum_t'(month_len(mon_reg, leap));
            end
            S_DIFF:
            begin
                op_a = acc_reg;
                op_b = n1_reg;
            end
            default:
            begin
                op_a = rem_reg;
            end
        endcase
        if (state_reg == S_HIGH)
        begin
            op_b = rem_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        n1_next     = n1_reg;
        lvl_next    = lvl_reg;
        k_next      = k_reg;
        qa_next     = qa_reg;
        qb_next     = qb_reg;
        qc_next     = qc_reg;
        yzero_next  = yzero_reg;
        mon_next    = mon_reg;
        cur_m_next  = cur_m_reg;
        cur_d_next  = cur_d_reg;
        pass_next   = pass_reg;
        err_next    = err_reg;
        year_next   = year_reg;
        action_next = action_reg;
        sy_next     = sy_reg;
        sm_next     = sm_reg;
        sd_next     = sd_reg;
        off_next    = off_reg;
        done_next   = 1'b0;
        ryear_next  = ryear_reg;
        rmon_next   = rmon_reg;
        rday_next   = rday_reg;
        rdiff_next  = rdiff_reg;
        rerr_next   = rerr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next = action;
                    sy_next     = second_year;
                    sm_next     = second_month;
                    sd_next     = second_day;
                    off_next    = day_offset;
                    rem_next    = year_base(first_year);
                    acc_next    = '0;
                    lvl_next    = LVL_400;
                    k_next      = FWD_K400;
                    qa_next     = '0;
                    qb_next     = '0;
                    qc_next     = '0;
                    yzero_next  = (first_year == '0);
                    mon_next    = 4'd1;
                    cur_m_next  = first_month;
                    cur_d_next  = first_day;
                    pass_next   = 1'b0;
                    err_next    = 1'b0;
                    state_next  = S_FYEAR;
                end
            end

            S_FYEAR, S_RYEAR:
            begin
                // Restoring division by each block size, largest multiple
                // first; the quotient bits of the lower levels are kept for
                // the leap-year test.
                if (step.take)
                begin
                    rem_next = step.diff;
                    acc_next = step.sum;
                end
                case (lvl_reg)
                    LVL_100: qa_next = {qa_reg[0], step.take};
                    LVL_4:   qb_next = {qb_reg[3:0], step.take};
                    LVL_1:   qc_next = {qc_reg[0], step.take};
                    default: qa_next = qa_reg;
                endcase
                if (k_reg == '0)
                begin
                    if (lvl_reg == LVL_1)
                    begin
                        state_next = (state_reg == S_FYEAR) ? S_FMON : S_RYFIX;
                    end
                    else
                    begin
                        lvl_next = lvl_succ(lvl_reg);
                        k_next   = blk_kmax(lvl_succ(lvl_reg));
                    end
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end

            S_FMON:
            begin
                // Add each month before the given one, then the day.
                acc_next = step.sum;
                if (mon_more)
                begin
                    mon_next = mon_reg + 4'd1;
                end
                else if (!pass_reg)
                begin
                    n1_next = step.sum;
                    if (!action_reg)
                    begin
                        state_next = S_OFS;
                    end
                    else
                    begin
                        rem_next   = year_base(sy_reg);
                        acc_next   = '0;
                        lvl_next   = LVL_400;
                        k_next     = FWD_K400;
                        qa_next    = '0;
                        qb_next    = '0;
                        qc_next    = '0;
                        yzero_next = (sy_reg == '0);
                        mon_next   = 4'd1;
                        cur_m_next = sm_reg;
                        cur_d_next = sd_reg;
                        pass_next  = 1'b1;
                        state_next = S_FYEAR;
                    end
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end

            S_OFS:
            begin
                acc_next   = step.sum;
                state_next = S_LOW;
            end

            S_LOW:
            begin
                // rem becomes the day number less one, floored at zero.
                if (step.take)
                begin
                    rem_next = step.diff;
                end
                else
                begin
                    rem_next = '0;
                    err_next = 1'b1;
                end
                state_next = S_HIGH;
            end

            S_HIGH:
            begin
                if (!step.take)
                begin
                    rem_next = LAST_M1;
                    err_next = 1'b1;
                end
                acc_next   = '0;
                lvl_next   = LVL_400;
                k_next     = R_K400;
                qa_next    = '0;
                qb_next    = '0;
                qc_next    = '0;
                yzero_next = 1'b0;
                state_next = S_RYEAR;
            end

            S_RYFIX:
            begin
                year_next  = step.sum[YREG_W-1:0];
                mon_next   = 4'd1;
                state_next = S_RMON;
            end

            S_RMON:
            begin
                if ((mon_reg < 4'd12) && step.take)
                begin
                    rem_next = step.diff;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    ryear_next = year_reg[YEAR_W-1:0];
                    rmon_next  = mon_reg;
                    rday_next  = rem_reg[DAY_FW-1:0] + 5'd1;
                    rdiff_next = '0;
                    rerr_next  = err_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DIFF:
            begin
                if (step.diff[DAY_W-1] || (step.diff == '0))
                begin
                    rdiff_next = DIFF_W'(1);
                end
                else if (step.diff > dnum_t'(DIFF_MAX))
                begin
                    rdiff_next = DIFF_MAX;
                end
                else
                begin
                    rdiff_next = step.diff[DIFF_W-1:0];
                end
                ryear_next = '0;
                rmon_next  = '0;
                rday_next  = '0;
                rerr_next  = 1'b0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        n1_reg     <= n1_next;
        lvl_reg    <= lvl_next;
        k_reg      <= k_next;
        qa_reg     <= qa_next;
        qb_reg     <= qb_next;
        qc_reg     <= qc_next;
        yzero_reg  <= yzero_next;
        mon_reg    <= mon_next;
        cur_m_reg  <= cur_m_next;
        cur_d_reg  <= cur_d_next;
        pass_reg   <= pass_next;
        err_reg    <= err_next;
        year_reg   <= year_next;
        action_reg <= action_next;
        sy_reg     <= sy_next;
        sm_reg     <= sm_next;
        sd_reg     <= sd_next;
        off_reg    <= off_next;
        ryear_reg  <= ryear_next;
        rmon_reg   <= rmon_next;
        rday_reg   <= rday_next;
        rdiff_reg  <= rdiff_next;
        rerr_reg   <= rerr_next;
    end

    assign done           = done_reg;
    assign result_year    = ryear_reg;
    assign result_month   = rmon_reg;
    assign result_day     = rday_reg;
    assign day_difference = rdiff_reg;
    assign range_error    = rerr_reg;

    // A result only follows the last step of a month search or a
    // difference.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_RMON || state_reg == S_DIFF))
        else $error("result strobe without a finishing step");

    // A taken request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // A shifted date always has a real month and day.
    a_add_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (day_difference == '0)) |->
            ((result_month >= 4'd1) && (result_month <= 4'd12) && (result_day != '0)))
        else $error("shifted date out of calendar");

    // A difference never raises the range flag.
    a_diff_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (day_difference != '0)) |-> !range_error)
        else $error("range flag on a difference");

endmodule
